FILE: hw/rtl/rsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rsi_pkg;

	localparam int COORD_W    = 32;
	localparam int FRAC_BITS  = 16;
	localparam int DIR_W      = FRAC_BITS + 2;
	localparam int RAD_W      = COORD_W - 1;
	localparam int T_W        = 31;
	localparam int OFF_W      = COORD_W + 1;
	localparam int PB_W       = DIR_W + OFF_W;
	localparam int SQ_W       = 2 * COORD_W - FRAC_BITS;
	localparam int RR_W       = 2 * RAD_W - FRAC_BITS;
	localparam int BSUM_W     = PB_W + 2;
	localparam int B_W        = 36;
	localparam int BMAG_W     = B_W - 1;
	localparam int B2_W       = 2 * BMAG_W - FRAC_BITS;
	localparam int C_W        = 52;
	localparam int DISC_W     = 56;
	localparam int DPOS_W     = 54;
	localparam int RADICAND_W = DPOS_W + FRAC_BITS;
	localparam int ROOT_W     = RADICAND_W / 2;
	localparam int REM_W      = ROOT_W + 2;
	localparam int TC_W       = B_W + 2;
	localparam int TPROD_W    = T_W + 1 + DIR_W;
	localparam int TSH_W      = TPROD_W - FRAC_BITS;
	localparam int PSUM_W     = COORD_W + 3;
	localparam int DIV_N_W    = COORD_W + FRAC_BITS;
	localparam int DIV_R_W    = RAD_W + 1;

	localparam int CFG_ADDR_W = 2;
	localparam logic [CFG_ADDR_W-1:0] CFG_T_MIN = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_T_MAX = 2'd1;
	localparam logic [T_W-1:0] T_MIN_RST = 31'd66;
	localparam logic [T_W-1:0] T_MAX_RST = 31'h7fff_ffff;

	localparam logic [COORD_W-1:0] T_MISS    = 32'hffff_0000;
	localparam logic [COORD_W-1:0] COORD_MAX = 32'h7fff_ffff;
	localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [2:0][COORD_W-1:0] o;
		logic [2:0][DIR_W-1:0]   d;
		logic [2:0][COORD_W-1:0] c;
		logic [RAD_W-1:0]        r;
	} ray_t;

	typedef struct packed {
		ray_t                  ray;
		logic                  live;
		logic [B_W-1:0]        b;
		logic [RADICAND_W-1:0] rad;
	} root_ctx_t;

	typedef struct packed {
		logic                    found;
		logic [T_W-1:0]          t;
		logic [2:0][COORD_W-1:0] p;
		logic [RAD_W-1:0]        r;
	} div_ctx_t;

	function automatic logic [COORD_W-1:0] sat_coord(input logic signed [PSUM_W-1:0] x);
		logic signed [PSUM_W-1:0] hi;
		logic signed [PSUM_W-1:0] lo;
		hi = $signed({{(PSUM_W-COORD_W){1'b0}}, COORD_MAX});
		lo = $signed({{(PSUM_W-COORD_W){1'b1}}, COORD_MIN});
		if (x > hi) return COORD_MAX;
		if (x < lo) return COORD_MIN;
		return x[COORD_W-1:0];
	endfunction

	// signed result from magnitude quotient, clamped to the coordinate range
	function automatic logic [COORD_W-1:0] sat_quot(input logic neg,
			input logic [DIV_N_W-1:0] q);
		if (!neg) begin
			if (q > {{(DIV_N_W-COORD_W){1'b0}}, COORD_MAX}) return COORD_MAX;
			return q[COORD_W-1:0];
		end
		if (q > {{(DIV_N_W-COORD_W){1'b0}}, COORD_MIN}) return COORD_MIN;
		return -q[COORD_W-1:0];
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/rsi_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rsi_in_if;
	logic valid;
	logic ready;
	logic signed [rsi_pkg::COORD_W-1:0] origin_x, origin_y, origin_z;
	logic signed [rsi_pkg::DIR_W-1:0]   dir_x, dir_y, dir_z;
	logic signed [rsi_pkg::COORD_W-1:0] center_x, center_y, center_z;
	logic [rsi_pkg::RAD_W-1:0]          sphere_radius;
	modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		center_x, center_y, center_z, sphere_radius, input ready);
	modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		center_x, center_y, center_z, sphere_radius, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rsi_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rsi_out_if;
	logic valid;
	logic ready;
	logic hit_found;
	logic signed [rsi_pkg::COORD_W-1:0] hit_t;
	logic signed [rsi_pkg::COORD_W-1:0] point_x, point_y, point_z;
	logic signed [rsi_pkg::COORD_W-1:0] normal_x, normal_y, normal_z;
	modport source (output valid, hit_found, hit_t, point_x, point_y, point_z,
		normal_x, normal_y, normal_z, input ready);
	modport sink (input valid, hit_found, hit_t, point_x, point_y, point_z,
		normal_x, normal_y, normal_z, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rsi_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rsi_cfg_if;
	logic valid;
	logic ready;
	logic [rsi_pkg::CFG_ADDR_W-1:0] addr;
	logic [rsi_pkg::T_W-1:0]        data;
	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rsi_setup.sv
`timescale 1ns / 1ps
`default_nettype none
module rsi_setup (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire rsi_pkg::ray_t      ray,
	output logic                    out_valid,
	output rsi_pkg::root_ctx_t      ctx
);
	logic [4:0] v_q;
	rsi_pkg::ray_t ray_s1, ray_s2, ray_s3, ray_s4;
	logic [2:0][rsi_pkg::OFF_W-1:0] off_s1;
	logic [2:0][rsi_pkg::PB_W-1:0]  pb_s2;
	logic [2:0][rsi_pkg::SQ_W-1:0]  sq_s2;
	logic [rsi_pkg::RR_W-1:0]       rr_s2;
	logic [rsi_pkg::B_W-1:0]        b_s3, b_s4;
	logic [rsi_pkg::C_W-1:0]        c_s3, c_s4;
	logic [rsi_pkg::B2_W-1:0]       b2_s4;
	rsi_pkg::root_ctx_t             ctx_s5;

	logic [2:0][rsi_pkg::COORD_W-1:0]   mag;
	logic [2:0][2*rsi_pkg::COORD_W-1:0] msq;
	logic [2*rsi_pkg::RAD_W-1:0]        rsq;
	logic signed [rsi_pkg::BSUM_W-1:0]  bsum;
	logic signed [rsi_pkg::C_W-1:0]     csum;
	logic [rsi_pkg::BMAG_W-1:0]         bmag;
	logic [2*rsi_pkg::BMAG_W-1:0]       bsq;
	logic signed [rsi_pkg::DISC_W-1:0]  disc;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = off_s1[i][rsi_pkg::OFF_W-1] ? rsi_pkg::COORD_W'(-off_s1[i])
				: off_s1[i][rsi_pkg::COORD_W-1:0];
			msq[i] = mag[i] * mag[i];
		end
		rsq = ray_s1.r * ray_s1.r;
		bsum = $signed({{2{pb_s2[0][rsi_pkg::PB_W-1]}}, pb_s2[0]})
			+ $signed({{2{pb_s2[1][rsi_pkg::PB_W-1]}}, pb_s2[1]})
			+ $signed({{2{pb_s2[2][rsi_pkg::PB_W-1]}}, pb_s2[2]});
		csum = $signed({4'b0, sq_s2[0]}) + $signed({4'b0, sq_s2[1]})
			+ $signed({4'b0, sq_s2[2]}) - $signed({6'b0, rr_s2});
		bmag = b_s3[rsi_pkg::B_W-1] ? rsi_pkg::BMAG_W'(-b_s3) : b_s3[rsi_pkg::BMAG_W-1:0];
		bsq = bmag * bmag;
		disc = $signed({2'b0, b2_s4}) - $signed({{4{c_s4[rsi_pkg::C_W-1]}}, c_s4});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[3:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s1 <= ray;
			for (int i = 0; i < 3; i++) begin
				off_s1[i] <= $signed({ray.o[i][rsi_pkg::COORD_W-1], ray.o[i]})
					- $signed({ray.c[i][rsi_pkg::COORD_W-1], ray.c[i]});
			end
			ray_s2 <= ray_s1;
			for (int i = 0; i < 3; i++) begin
				pb_s2[i] <= $signed(ray_s1.d[i]) * $signed(off_s1[i]);
				sq_s2[i] <= msq[i][2*rsi_pkg::COORD_W-1:rsi_pkg::FRAC_BITS];
			end
			rr_s2 <= rsq[2*rsi_pkg::RAD_W-1:rsi_pkg::FRAC_BITS];
			// floor shift of the dot product
			ray_s3 <= ray_s2;
			b_s3   <= bsum[rsi_pkg::B_W+rsi_pkg::FRAC_BITS-1:rsi_pkg::FRAC_BITS];
			c_s3   <= csum;
			ray_s4 <= ray_s3;
			b_s4   <= b_s3;
			c_s4   <= c_s3;
			b2_s4  <= bsq[2*rsi_pkg::BMAG_W-1:rsi_pkg::FRAC_BITS];
			ctx_s5.ray  <= ray_s4;
			ctx_s5.b    <= b_s4;
			ctx_s5.live <= (ray_s4.r != '0) && !disc[rsi_pkg::DISC_W-1];
			ctx_s5.rad  <= {disc[rsi_pkg::DPOS_W-1:0], {rsi_pkg::FRAC_BITS{1'b0}}};
		end
	end

	assign out_valid = v_q[4];
	assign ctx       = ctx_s5;
endmodule
`default_nettype wire

FILE: hw/rtl/rsi_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module rsi_sqrt (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       in_valid,
	input  wire rsi_pkg::root_ctx_t         ctx_in,
	output logic                            out_valid,
	output rsi_pkg::root_ctx_t              ctx_out,
	output logic [rsi_pkg::ROOT_W-1:0]      root
);
	localparam int N = rsi_pkg::ROOT_W;

	logic [N-1:0] v_q;
	rsi_pkg::root_ctx_t ctx_s [N];
	logic [rsi_pkg::REM_W-1:0]  rem_s  [N];
	logic [rsi_pkg::ROOT_W-1:0] root_s [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[N-2:0], in_valid};
		end
	end

	// one result digit per stage, radicand pairs taken from the top
	for (genvar k = 0; k < N; k++) begin : g_step
		rsi_pkg::root_ctx_t         c_in;
		logic [rsi_pkg::REM_W-1:0]  rem_in, rem_sh, trial;
		logic [rsi_pkg::ROOT_W-1:0] root_in;
		logic                       ge;

		if (k == 0) begin : g_first
			assign c_in    = ctx_in;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign c_in    = ctx_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
		end

		assign rem_sh = {rem_in[rsi_pkg::REM_W-3:0],
			c_in.rad[rsi_pkg::RADICAND_W-1-2*k -: 2]};
		assign trial  = {root_in, 2'b01};
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_s[k]  <= c_in;
				rem_s[k]  <= ge ? rem_sh - trial : rem_sh;
				root_s[k] <= {root_in[rsi_pkg::ROOT_W-2:0], ge};
			end
		end
	end

	assign out_valid = v_q[N-1];
	assign ctx_out   = ctx_s[N-1];
	assign root      = root_s[N-1];
endmodule
`default_nettype wire

FILE: hw/rtl/rsi_hit.sv
`timescale 1ns / 1ps
`default_nettype none
module rsi_hit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            en,
	input  wire logic                            in_valid,
	input  wire rsi_pkg::root_ctx_t              ctx,
	input  wire logic [rsi_pkg::ROOT_W-1:0]      root,
	input  wire logic [rsi_pkg::T_W-1:0]         t_min,
	input  wire logic [rsi_pkg::T_W-1:0]         t_max,
	output logic                                 out_valid,
	output rsi_pkg::div_ctx_t                    dctx,
	output logic [2:0][rsi_pkg::OFF_W-1:0]       diff
);
	localparam int TC = rsi_pkg::TC_W;

	logic [2:0] v_q;
	rsi_pkg::ray_t ray_s1, ray_s2;
	logic found_s1, found_s2;
	logic [rsi_pkg::T_W-1:0] t_s1, t_s2;
	logic [2:0][rsi_pkg::TSH_W-1:0] sh_s2;
	rsi_pkg::div_ctx_t dctx_s3;
	logic [2:0][rsi_pkg::OFF_W-1:0] diff_s3;

	logic signed [TC-1:0] nb, s_ext, t1, t2, lo, hi;
	logic adm1, adm2;
	logic [2:0][rsi_pkg::TPROD_W-1:0] prod;
	logic [2:0][rsi_pkg::COORD_W-1:0] p;

	always_comb begin
		nb    = -$signed({{2{ctx.b[rsi_pkg::B_W-1]}}, ctx.b});
		s_ext = $signed({{(TC-rsi_pkg::ROOT_W){1'b0}}, root});
		t1    = nb - s_ext;
		t2    = nb + s_ext;
		lo    = $signed({{(TC-rsi_pkg::T_W){1'b0}}, t_min});
		hi    = $signed({{(TC-rsi_pkg::T_W){1'b0}}, t_max});
		adm1  = (t1 > lo) && (t1 < hi);
		adm2  = (t2 > lo) && (t2 < hi);
		for (int i = 0; i < 3; i++) begin
			prod[i] = $signed({1'b0, t_s1}) * $signed(ray_s1.d[i]);
			p[i] = rsi_pkg::sat_coord(
				$signed({{3{ray_s2.o[i][rsi_pkg::COORD_W-1]}}, ray_s2.o[i]})
				+ $signed({sh_s2[i][rsi_pkg::TSH_W-1], sh_s2[i]}));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// nearer root first, both bounds exclusive
			ray_s1   <= ctx.ray;
			found_s1 <= ctx.live && (adm1 || adm2);
			t_s1     <= adm1 ? t1[rsi_pkg::T_W-1:0] : t2[rsi_pkg::T_W-1:0];
			ray_s2   <= ray_s1;
			found_s2 <= found_s1;
			t_s2     <= t_s1;
			for (int i = 0; i < 3; i++) begin
				sh_s2[i] <= prod[i][rsi_pkg::TPROD_W-1:rsi_pkg::FRAC_BITS];
			end
			dctx_s3.found <= found_s2;
			dctx_s3.t     <= t_s2;
			dctx_s3.r     <= ray_s2.r;
			for (int i = 0; i < 3; i++) begin
				dctx_s3.p[i] <= p[i];
				diff_s3[i] <= $signed({p[i][rsi_pkg::COORD_W-1], p[i]})
					- $signed({ray_s2.c[i][rsi_pkg::COORD_W-1], ray_s2.c[i]});
			end
		end
	end

	assign out_valid = v_q[2];
	assign dctx      = dctx_s3;
	assign diff      = diff_s3;
endmodule
`default_nettype wire

FILE: hw/rtl/rsi_div.sv
`timescale 1ns / 1ps
`default_nettype none
module rsi_div (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire logic                              in_valid,
	input  wire rsi_pkg::div_ctx_t                 dctx_in,
	input  wire logic [2:0][rsi_pkg::OFF_W-1:0]    diff,
	output logic                                   out_valid,
	output rsi_pkg::div_ctx_t                      dctx_out,
	output logic [2:0]                             neg,
	output logic [2:0][rsi_pkg::DIV_N_W-1:0]       quot
);
	localparam int N = rsi_pkg::DIV_N_W;
	localparam int RW = rsi_pkg::DIV_R_W;

	logic [N-1:0] v_q;
	rsi_pkg::div_ctx_t ctx_s [N];
	logic [2:0]           neg_s [N];
	logic [2:0][RW-1:0]   rem_s [N];
	logic [2:0][N-1:0]    nq_s  [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[N-2:0], in_valid};
		end
	end

	// restoring division on magnitudes, quotient bits shift in behind the dividend
	for (genvar k = 0; k < N; k++) begin : g_step
		rsi_pkg::div_ctx_t  c_in;
		logic [2:0]         neg_in;
		logic [2:0][RW-1:0] rem_in, rem_sh, rem_nx;
		logic [2:0][N-1:0]  nq_in, nq_nx;
		logic [RW-1:0]      dvs;

		if (k == 0) begin : g_first
			logic [2:0][rsi_pkg::COORD_W-1:0] mag;
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					neg_in[i] = diff[i][rsi_pkg::OFF_W-1];
					mag[i] = neg_in[i] ? rsi_pkg::COORD_W'(-diff[i])
						: diff[i][rsi_pkg::COORD_W-1:0];
					nq_in[i]  = {mag[i], {rsi_pkg::FRAC_BITS{1'b0}}};
					rem_in[i] = '0;
				end
			end
			assign c_in = dctx_in;
		end else begin : g_next
			assign c_in   = ctx_s[k-1];
			assign neg_in = neg_s[k-1];
			assign rem_in = rem_s[k-1];
			assign nq_in  = nq_s[k-1];
		end

		assign dvs = {1'b0, c_in.r};

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				rem_sh[i] = {rem_in[i][RW-2:0], nq_in[i][N-1]};
				if (rem_sh[i] >= dvs) begin
					rem_nx[i] = rem_sh[i] - dvs;
					nq_nx[i]  = {nq_in[i][N-2:0], 1'b1};
				end else begin
					rem_nx[i] = rem_sh[i];
					nq_nx[i]  = {nq_in[i][N-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_s[k] <= c_in;
				neg_s[k] <= neg_in;
				rem_s[k] <= rem_nx;
				nq_s[k]  <= nq_nx;
			end
		end
	end

	assign out_valid = v_q[N-1];
	assign dctx_out  = ctx_s[N-1];
	assign neg       = neg_s[N-1];
	assign quot      = nq_s[N-1];
endmodule
`default_nettype wire

FILE: hw/rtl/ray_sphere_intersect_unit.sv
// Ray-sphere test. Each input word holds a ray (origin, unit direction in signed
// Q2.16) and a sphere (center, radius) in signed Q16.16; each output word gives
// the hit flag, t, the hit point and the normal (point-center)/radius, or
// t = -1.0 and zero vectors on a miss or a zero radius. The unit is a fully
// pipelined datapath of 92 register stages: 5 for the offset, dot product and
// discriminant, 35 for the square root (one result bit per stage), 3 for root
// choice and hit point, 48 for the three normal divisions (one quotient bit per
// stage) and one output register. A new word can enter every cycle; when the
// output word is not taken the whole pipe holds, and ready on the input drops
// with it. The user must write t_min (index 0) and t_max (index 1) through the
// configuration channel only while the unit is idle; it is not enforced.
`timescale 1ns / 1ps
`default_nettype none
module ray_sphere_intersect_unit (
	input wire logic  clk,
	input wire logic  arst_n,
	rsi_in_if.sink    ray,
	rsi_out_if.source hit,
	rsi_cfg_if.sink   cfg
);
	logic en;
	logic [rsi_pkg::T_W-1:0] t_min_q, t_max_q;
	rsi_pkg::ray_t ray_w;

	logic su_valid, sq_valid, ht_valid, dv_valid;
	rsi_pkg::root_ctx_t su_ctx, sq_ctx;
	logic [rsi_pkg::ROOT_W-1:0] sq_root;
	rsi_pkg::div_ctx_t ht_ctx, dv_ctx;
	logic [2:0][rsi_pkg::OFF_W-1:0] ht_diff;
	logic [2:0] dv_neg;
	logic [2:0][rsi_pkg::DIV_N_W-1:0] dv_quot;

	logic out_v_q;
	logic found_q;
	logic [rsi_pkg::COORD_W-1:0] t_q;
	logic [2:0][rsi_pkg::COORD_W-1:0] pt_q, nrm_q;

	assign en        = !out_v_q || hit.ready;
	assign ray.ready = en;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_min_q <= rsi_pkg::T_MIN_RST;
			t_max_q <= rsi_pkg::T_MAX_RST;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				rsi_pkg::CFG_T_MIN: t_min_q <= cfg.data;
				rsi_pkg::CFG_T_MAX: t_max_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign ray_w.o = {ray.origin_z, ray.origin_y, ray.origin_x};
	assign ray_w.d = {ray.dir_z, ray.dir_y, ray.dir_x};
	assign ray_w.c = {ray.center_z, ray.center_y, ray.center_x};
	assign ray_w.r = ray.sphere_radius;

	rsi_setup u_setup (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(ray.valid), .ray(ray_w),
		.out_valid(su_valid), .ctx(su_ctx)
	);

	rsi_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(su_valid), .ctx_in(su_ctx),
		.out_valid(sq_valid), .ctx_out(sq_ctx), .root(sq_root)
	);

	rsi_hit u_hit (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(sq_valid), .ctx(sq_ctx), .root(sq_root),
		.t_min(t_min_q), .t_max(t_max_q),
		.out_valid(ht_valid), .dctx(ht_ctx), .diff(ht_diff)
	);

	rsi_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(ht_valid), .dctx_in(ht_ctx), .diff(ht_diff),
		.out_valid(dv_valid), .dctx_out(dv_ctx), .neg(dv_neg), .quot(dv_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			found_q <= dv_ctx.found;
			t_q <= dv_ctx.found ? {1'b0, dv_ctx.t} : rsi_pkg::T_MISS;
			for (int i = 0; i < 3; i++) begin
				pt_q[i]  <= dv_ctx.found ? dv_ctx.p[i] : '0;
				nrm_q[i] <= dv_ctx.found ? rsi_pkg::sat_quot(dv_neg[i], dv_quot[i]) : '0;
			end
		end
	end

	assign hit.valid     = out_v_q;
	assign hit.hit_found = found_q;
	assign hit.hit_t     = t_q;
	assign hit.point_x   = pt_q[0];
	assign hit.point_y   = pt_q[1];
	assign hit.point_z   = pt_q[2];
	assign hit.normal_x  = nrm_q[0];
	assign hit.normal_y  = nrm_q[1];
	assign hit.normal_z  = nrm_q[2];
endmodule
`default_nettype wire

FILE: hw/rtl/rsi_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module rsi_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic                        hit_found,
	input wire logic [rsi_pkg::COORD_W-1:0] hit_t,
	input wire logic [rsi_pkg::COORD_W-1:0] point_x,
	input wire logic [rsi_pkg::COORD_W-1:0] normal_x
);
	// a word not taken stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	// a stalled output holds the whole pipe, so no input is taken
	a_stall_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while output stalled");

	a_miss_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit_found |->
		hit_t == rsi_pkg::T_MISS && point_x == '0 && normal_x == '0)
		else $error("miss word not in its fixed form");

	a_hit_t_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit_found |-> !hit_t[rsi_pkg::COORD_W-1] && hit_t != '0)
		else $error("hit with non-positive t");
endmodule

bind ray_sphere_intersect_unit rsi_checker u_rsi_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(ray.ready),
	.out_valid(hit.valid),
	.out_ready(hit.ready),
	.hit_found(hit.hit_found),
	.hit_t(hit.hit_t),
	.point_x(hit.point_x),
	.normal_x(hit.normal_x)
);
`default_nettype wire
